@@ src/csfs_pkg.sv @@
// Shared types and constants for the smallest-first coin selector.
// Used by csfs_front, csfs_back and the top level; no dependencies.
package csfs_pkg;

   localparam int VAL_W         = 64;
   localparam int MAX_COINS_DEF = 64;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_SELECT = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;
   localparam logic [1:0] FUNC_SPARE  = 2'd3;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_BAD_TARGET = 2'd1;
   localparam logic [1:0] STAT_SHORT      = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW   = 2'd3;

   localparam logic [1:0] REG_CHAIN_HEIGHT = 2'd0;
   localparam logic [1:0] REG_FILTER_ON    = 2'd1;
   localparam logic [1:0] REG_TOKEN_TAG    = 2'd2;

   typedef struct packed {
      logic [1:0]       func;
      logic [VAL_W-1:0] amount;
      logic [VAL_W-1:0] unlock;
      logic [VAL_W-1:0] token;
      logic [VAL_W-1:0] tie_key;
      logic [VAL_W-1:0] target;
   } cmd_type;

   typedef struct packed {
      logic [VAL_W-1:0] amount;
      logic [VAL_W-1:0] unlock;
      logic [VAL_W-1:0] token;
      logic [VAL_W-1:0] tie_key;
   } coin_type;

   typedef struct packed {
      logic [VAL_W-1:0] chain_height;
      logic             filter_on;
      logic [VAL_W-1:0] token_tag;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [5:0]       coin_slot;
      logic [VAL_W-1:0] picked_amount;
      logic [VAL_W-1:0] picked_tie_key;
      logic [6:0]       pick_total;
      logic [VAL_W-1:0] change_left;
      logic             last;
   } rsp_type;

endpackage

@@ src/csfs_front.sv @@
// Front end: accepts request transfers and queues them as commands.
// Two-entry queue toward csfs_back; depends on csfs_pkg.
module csfs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  csfs_pkg::cmd_type req_cmd,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output csfs_pkg::cmd_type cmd
);
   import csfs_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   logic       pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop)      cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

endmodule

@@ src/csfs_back.sv @@
// Back end: coin store, filtered total, repeated min-scan selection, emit.
// Takes commands from csfs_front; depends on csfs_pkg.
module csfs_back #(
   parameter int MAX_COINS = csfs_pkg::MAX_COINS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  csfs_pkg::cmd_type cmd,
   input  csfs_pkg::cfg_type cfg,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output csfs_pkg::rsp_type rsp
);
   import csfs_pkg::*;

   localparam int SLOT_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
   localparam int CNT_W  = $clog2(MAX_COINS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COINS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUM, ST_CHECK, ST_PICK, ST_PICK_END,
      ST_EMIT_A, ST_EMIT_B, ST_EMIT_C, ST_ERR
   } state_type;

   coin_type          coin_mem [MAX_COINS];
   logic [SLOT_W-1:0] pick_mem [MAX_COINS];

   state_type         state_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  idx_ff;
   coin_type          rd_data_ff;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic              rd_vld_ff;
   logic [VAL_W-1:0]  total_ff;
   logic              ovf_ff;
   logic [CNT_W-1:0]  kept_ff;
   logic [VAL_W-1:0]  target_ff;
   logic [VAL_W-1:0]  acc_ff;
   logic [CNT_W-1:0]  picked_ff;
   logic [VAL_W-1:0]  prev_amt_ff;
   logic [VAL_W-1:0]  prev_key_ff;
   logic [SLOT_W-1:0] prev_slot_ff;
   logic              have_prev_ff;
   logic              best_vld_ff;
   logic [VAL_W-1:0]  best_amt_ff;
   logic [VAL_W-1:0]  best_key_ff;
   logic [SLOT_W-1:0] best_slot_ff;
   logic [CNT_W-1:0]  emit_ff;
   logic [SLOT_W-1:0] pick_rd_ff;
   logic [1:0]        err_code_ff;
   logic [VAL_W-1:0]  change_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic              issue;
   logic [SLOT_W-1:0] rd_addr;
   logic              eligible;
   logic              scan_last;
   logic [VAL_W:0]    sum_ext;
   logic              after_prev;
   logic              before_best;
   logic              take;
   logic [VAL_W-1:0]  acc_next;
   logic              out_free;
   logic              load_wr;
   logic              emit_last;
   logic              rsp_load;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign issue = ((state_ff == ST_SUM) || (state_ff == ST_PICK)) && (idx_ff < count_ff);
   assign rd_addr = ((state_ff == ST_EMIT_B) || (state_ff == ST_EMIT_C)) ?
                    pick_rd_ff : idx_ff[SLOT_W-1:0];
   assign eligible = (rd_data_ff.unlock <= cfg.chain_height) &&
                     (!cfg.filter_on || (rd_data_ff.token == cfg.token_tag));
   assign scan_last = rd_vld_ff && ((CNT_W'(rd_slot_ff) + CNT_W'(1)) == count_ff);
   assign sum_ext = {1'b0, total_ff} + {1'b0, rd_data_ff.amount};
   assign after_prev = !have_prev_ff ||
                       (rd_data_ff.amount > prev_amt_ff) ||
                       ((rd_data_ff.amount == prev_amt_ff) &&
                        ((rd_data_ff.tie_key > prev_key_ff) ||
                         ((rd_data_ff.tie_key == prev_key_ff) && (rd_slot_ff > prev_slot_ff))));
   assign before_best = !best_vld_ff ||
                        (rd_data_ff.amount < best_amt_ff) ||
                        ((rd_data_ff.amount == best_amt_ff) &&
                         (rd_data_ff.tie_key < best_key_ff));
   assign take      = rd_vld_ff && eligible && after_prev && before_best;
   assign acc_next  = acc_ff + best_amt_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_wr   = (state_ff == ST_IDLE) && cmd_valid && (cmd.func == FUNC_LOAD) &&
                      (count_ff < MAX_CNT);
   assign emit_last = ((emit_ff + CNT_W'(1)) == picked_ff);
   assign rsp_load  = ((state_ff == ST_EMIT_C) || (state_ff == ST_ERR)) && out_free;

   always_ff @(posedge clock) begin
      if (load_wr) begin
         coin_mem[count_ff[SLOT_W-1:0]] <= '{amount: cmd.amount, unlock: cmd.unlock,
                                             token: cmd.token, tie_key: cmd.tie_key};
      end
      rd_data_ff <= coin_mem[rd_addr];
      if (state_ff == ST_PICK_END) begin
         pick_mem[picked_ff[SLOT_W-1:0]] <= best_slot_ff;
      end
      pick_rd_ff <= pick_mem[emit_ff[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         best_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff  <= issue;
         rd_slot_ff <= idx_ff[SLOT_W-1:0];
         if (issue) idx_ff <= idx_ff + CNT_W'(1);
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  case (cmd.func)
                     FUNC_LOAD: begin
                        if (count_ff < MAX_CNT) count_ff <= count_ff + CNT_W'(1);
                     end
                     FUNC_CLEAR: count_ff <= '0;
                     FUNC_SELECT: begin
                        target_ff <= cmd.target;
                        if (cmd.target == '0) begin
                           err_code_ff <= STAT_BAD_TARGET;
                           state_ff    <= ST_ERR;
                        end else if (count_ff == '0) begin
                           err_code_ff <= STAT_SHORT;
                           state_ff    <= ST_ERR;
                        end else begin
                           idx_ff   <= '0;
                           total_ff <= '0;
                           ovf_ff   <= 1'b0;
                           kept_ff  <= '0;
                           state_ff <= ST_SUM;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_SUM: begin
               if (rd_vld_ff && eligible) begin
                  total_ff <= sum_ext[VAL_W-1:0];
                  if (sum_ext[VAL_W]) ovf_ff <= 1'b1;
                  kept_ff <= kept_ff + CNT_W'(1);
               end
               if (scan_last) state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (ovf_ff) begin
                  err_code_ff <= STAT_OVERFLOW;
                  state_ff    <= ST_ERR;
               end else if ((kept_ff == '0) || (total_ff < target_ff)) begin
                  err_code_ff <= STAT_SHORT;
                  state_ff    <= ST_ERR;
               end else begin
                  acc_ff       <= '0;
                  picked_ff    <= '0;
                  have_prev_ff <= 1'b0;
                  best_vld_ff  <= 1'b0;
                  idx_ff       <= '0;
                  state_ff     <= ST_PICK;
               end
            end
            ST_PICK: begin
               if (take) begin
                  best_vld_ff  <= 1'b1;
                  best_amt_ff  <= rd_data_ff.amount;
                  best_key_ff  <= rd_data_ff.tie_key;
                  best_slot_ff <= rd_slot_ff;
               end
               if (scan_last) state_ff <= ST_PICK_END;
            end
            ST_PICK_END: begin
               acc_ff       <= acc_next;
               picked_ff    <= picked_ff + CNT_W'(1);
               prev_amt_ff  <= best_amt_ff;
               prev_key_ff  <= best_key_ff;
               prev_slot_ff <= best_slot_ff;
               have_prev_ff <= 1'b1;
               best_vld_ff  <= 1'b0;
               idx_ff       <= '0;
               if (acc_next >= target_ff) begin
                  change_ff <= acc_next - target_ff;
                  emit_ff   <= '0;
                  state_ff  <= ST_EMIT_A;
               end else begin
                  state_ff <= ST_PICK;
               end
            end
            ST_EMIT_A: state_ff <= ST_EMIT_B;
            ST_EMIT_B: state_ff <= ST_EMIT_C;
            ST_EMIT_C: begin
               if (out_free) begin
                  rsp_ff.status         <= STAT_OK;
                  rsp_ff.coin_slot      <= 6'(pick_rd_ff);
                  rsp_ff.picked_amount  <= rd_data_ff.amount;
                  rsp_ff.picked_tie_key <= rd_data_ff.tie_key;
                  rsp_ff.pick_total     <= 7'(picked_ff);
                  rsp_ff.change_left    <= change_ff;
                  rsp_ff.last           <= emit_last;
                  emit_ff               <= emit_ff + CNT_W'(1);
                  state_ff              <= emit_last ? ST_IDLE : ST_EMIT_A;
               end
            end
            ST_ERR: begin
               if (out_free) begin
                  rsp_ff       <= '{status: err_code_ff, coin_slot: '0, picked_amount: '0,
                                    picked_tie_key: '0, pick_total: '0,
                                    change_left: '0, last: 1'b1};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("coin count above capacity");
   a_pick_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PICK_END |-> best_vld_ff) else $error("pick scan found no coin");
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_C |-> emit_ff < picked_ff) else $error("emit index past picks");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STAT_OK |-> rsp_ff.last)
      else $error("error result not marked last");

endmodule

@@ src/smallest_first_coin_selector.sv @@
// Smallest-first coin selector, top level: APB-style CSRs, front and back.
// Depends on csfs_pkg, csfs_front and csfs_back.
//
// Usage: req_ transfers carry a command. Load stores one coin (ignored when
// the store is full), clear empties the store, select runs a selection over
// the stored coins. Loads and clears give no rsp_ transfer. A select gives one
// rsp_ transfer per picked coin in ascending (amount, tie key, slot) order,
// or a single error transfer; the final one has last set.
// Commands pass a two-entry queue. A select first forms the filtered total,
// then repeats minimum scans over the stored coins through the single coin
// memory read port, one scan per picked coin, and then emits the results.
// The next command waits until the selection is emitted. Reset empties the
// store and the queue and zeroes the CSRs. If the receiver stalls, the result
// stays in the output register and the back end holds. CSRs (64-bit, byte
// address 8*i): chain_height, token_filter_on, token_tag. The CSRs are to be
// written by the user only while idle; the block does not enforce this.
// pready is always high.
module smallest_first_coin_selector #(
   parameter int MAX_COINS = csfs_pkg::MAX_COINS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic [csfs_pkg::VAL_W-1:0] req_coin_amount,
   input  logic [csfs_pkg::VAL_W-1:0] req_coin_unlock,
   input  logic [csfs_pkg::VAL_W-1:0] req_coin_token,
   input  logic [csfs_pkg::VAL_W-1:0] req_coin_tie_key,
   input  logic [csfs_pkg::VAL_W-1:0] req_target_amount,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [5:0]                 rsp_coin_slot,
   output logic [csfs_pkg::VAL_W-1:0] rsp_picked_amount,
   output logic [csfs_pkg::VAL_W-1:0] rsp_picked_tie_key,
   output logic [6:0]                 rsp_pick_total,
   output logic [csfs_pkg::VAL_W-1:0] rsp_change_left,
   output logic                       rsp_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [4:0]                 paddr,
   input  logic [63:0]                pwdata,
   output logic [63:0]                prdata,
   output logic                       pready
);
   import csfs_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    req_cmd;
   cmd_type    cmd;
   logic       cmd_valid;
   logic       cmd_ready;
   rsp_type    rsp;
   logic       csr_wr;
   logic [1:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[4:3];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CHAIN_HEIGHT: cfg_ff.chain_height <= pwdata;
            REG_FILTER_ON:    cfg_ff.filter_on    <= pwdata[0];
            REG_TOKEN_TAG:    cfg_ff.token_tag    <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CHAIN_HEIGHT: prdata = cfg_ff.chain_height;
         REG_FILTER_ON:    prdata = {63'd0, cfg_ff.filter_on};
         REG_TOKEN_TAG:    prdata = cfg_ff.token_tag;
         default:          prdata = '0;
      endcase
   end

   assign req_cmd = '{func: req_func, amount: req_coin_amount, unlock: req_coin_unlock,
                      token: req_coin_token, tie_key: req_coin_tie_key,
                      target: req_target_amount};

   csfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   csfs_back #(.MAX_COINS(MAX_COINS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_status         = rsp.status;
   assign rsp_coin_slot      = rsp.coin_slot;
   assign rsp_picked_amount  = rsp.picked_amount;
   assign rsp_picked_tie_key = rsp.picked_tie_key;
   assign rsp_pick_total     = rsp.pick_total;
   assign rsp_change_left    = rsp.change_left;
   assign rsp_last           = rsp.last;

endmodule

@@ dv/tb_smallest_first_coin_selector.sv @@
// Testbench for smallest_first_coin_selector: directed and random commands, a scoreboard
// checking every result against a built-in greedy selection predictor.
// Depends on csfs_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb_smallest_first_coin_selector;
   import csfs_pkg::*;

   localparam int STORE_DEPTH = 64;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_LOAD;
   logic [63:0] req_coin_amount = 0;
   logic [63:0] req_coin_unlock = 0;
   logic [63:0] req_coin_token = 0;
   logic [63:0] req_coin_tie_key = 0;
   logic [63:0] req_target_amount = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_coin_slot;
   logic [63:0] rsp_picked_amount;
   logic [63:0] rsp_picked_tie_key;
   logic [6:0]  rsp_pick_total;
   logic [63:0] rsp_change_left;
   logic        rsp_last;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [4:0]  paddr = 0;
   logic [63:0] pwdata = 0;
   logic [63:0] prdata;
   logic        pready;

   smallest_first_coin_selector u_top (.*);

   // predictor state
   logic [63:0] coin_amt [STORE_DEPTH];
   logic [63:0] coin_unl [STORE_DEPTH];
   logic [63:0] coin_tok [STORE_DEPTH];
   logic [63:0] coin_key [STORE_DEPTH];
   int          coin_total_n = 0;
   logic [63:0] cfg_height = 0;
   logic        cfg_filter = 0;
   logic [63:0] cfg_tag = 0;

   rsp_type     expected_picks[$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          selects_sent = 0;
   int          ok_selects = 0;
   int          err_results = 0;
   bit          no_idle = 0;
   int          hold_ask = 0;
   int          hold_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit coin_less(int a, int b);
      if (coin_amt[a] != coin_amt[b]) return coin_amt[a] < coin_amt[b];
      if (coin_key[a] != coin_key[b]) return coin_key[a] < coin_key[b];
      return a < b;
   endfunction

   task automatic push_error(logic [1:0] code);
      rsp_type r;
      r = '0;
      r.status = code;
      r.last = 1'b1;
      expected_picks.push_back(r);
      err_results++;
   endtask

   task automatic predict_command(logic [1:0] f, logic [63:0] amt, logic [63:0] unl,
                                  logic [63:0] tok, logic [63:0] key, logic [63:0] tgt);
      int          order[$];
      int          tmp, j, picked;
      logic [64:0] total;
      logic [63:0] accum;
      bit          ovf;
      rsp_type     r;
      case (f)
         FUNC_LOAD: begin
            if (coin_total_n < STORE_DEPTH) begin
               coin_amt[coin_total_n] = amt;
               coin_unl[coin_total_n] = unl;
               coin_tok[coin_total_n] = tok;
               coin_key[coin_total_n] = key;
               coin_total_n++;
            end
         end
         FUNC_CLEAR: coin_total_n = 0;
         FUNC_SELECT: begin
            selects_sent++;
            if (tgt == 0) begin
               push_error(STAT_BAD_TARGET);
               return;
            end
            for (int i = 0; i < coin_total_n; i++)
               if (coin_unl[i] <= cfg_height && (!cfg_filter || coin_tok[i] == cfg_tag))
                  order.push_back(i);
            for (int i = 1; i < order.size(); i++) begin
               j = i;
               while (j > 0 && coin_less(order[j], order[j-1])) begin
                  tmp = order[j]; order[j] = order[j-1]; order[j-1] = tmp;
                  j--;
               end
            end
            total = 0;
            ovf = 0;
            foreach (order[i]) begin
               total = total + coin_amt[order[i]];
               if (total[64]) ovf = 1;
            end
            if (order.size() == 0) push_error(STAT_SHORT);
            else if (ovf) push_error(STAT_OVERFLOW);
            else if (total[63:0] < tgt) push_error(STAT_SHORT);
            else begin
               accum = 0;
               picked = 0;
               while (picked < order.size() && accum < tgt) begin
                  accum += coin_amt[order[picked]];
                  picked++;
               end
               ok_selects++;
               for (int i = 0; i < picked; i++) begin
                  r.status = STAT_OK;
                  r.coin_slot = 6'(order[i]);
                  r.picked_amount = coin_amt[order[i]];
                  r.picked_tie_key = coin_key[order[i]];
                  r.pick_total = 7'(picked);
                  r.change_left = accum - tgt;
                  r.last = (i + 1 == picked);
                  expected_picks.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   // one command transfer; prediction at the accepting edge
   task automatic send_cmd(logic [1:0] f, logic [63:0] amt = 0, logic [63:0] unl = 0,
                           logic [63:0] tok = 0, logic [63:0] key = 0, logic [63:0] tgt = 0);
      if (!no_idle && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_coin_amount <= amt;
      req_coin_unlock <= unl;
      req_coin_token <= tok;
      req_coin_tie_key <= key;
      req_target_amount <= tgt;
      do @(posedge clock); while (!req_ready);
      predict_command(f, amt, unl, tok, key, tgt);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (expected_picks.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] reg_idx, logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (reg_idx)
         REG_CHAIN_HEIGHT: cfg_height = value;
         REG_FILTER_ON:    cfg_filter = value[0];
         REG_TOKEN_TAG:    cfg_tag = value;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [63:0] height, logic filt, logic [63:0] tag);
      csr_write(REG_CHAIN_HEIGHT, height);
      csr_write(REG_FILTER_ON, {63'd0, filt});
      csr_write(REG_TOKEN_TAG, tag);
   endtask

   // receiver: random stalls, or a long counted hold when asked
   always @(posedge clock) begin
      if (hold_ask > 0) begin
         hold_left = hold_ask;
         hold_ask = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 9);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result transfer, status %0d slot %0d",
                        rsp_status, rsp_coin_slot);
         end else begin
            want = expected_picks.pop_front();
            if (rsp_status !== want.status || rsp_coin_slot !== want.coin_slot ||
                rsp_picked_amount !== want.picked_amount ||
                rsp_picked_tie_key !== want.picked_tie_key ||
                rsp_pick_total !== want.pick_total ||
                rsp_change_left !== want.change_left || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: exp st=%0d slot=%0d amt=%h key=%h cnt=%0d chg=%h last=%0d",
                           want.status, want.coin_slot, want.picked_amount,
                           want.picked_tie_key, want.pick_total, want.change_left,
                           want.last);
                  $display("       got st=%0d slot=%0d amt=%h key=%h cnt=%0d chg=%h last=%0d",
                           rsp_status, rsp_coin_slot, rsp_picked_amount, rsp_picked_tie_key,
                           rsp_pick_total, rsp_change_left, rsp_last);
               end
            end
         end
      end
   end

   task automatic test_errors();
      send_cmd(FUNC_SELECT, .tgt(64'd0));
      send_cmd(FUNC_SELECT, .tgt(64'd5));
      send_cmd(FUNC_LOAD, 64'd10, 64'd0, 64'd0, 64'd1);
      send_cmd(FUNC_SELECT, .tgt(64'd11));
      send_cmd(FUNC_SELECT, .tgt('1));
      send_cmd(FUNC_SPARE, '1, '1, '1, '1, '1);
      send_cmd(FUNC_SELECT, .tgt(64'd10));
      drain();
   endtask

   task automatic test_ordering();
      send_cmd(FUNC_CLEAR);
      send_cmd(FUNC_LOAD, 64'd7, 64'd0, 64'd0, 64'd3);
      send_cmd(FUNC_LOAD, 64'd0, 64'd0, 64'd0, '1);
      send_cmd(FUNC_LOAD, 64'd7, 64'd0, 64'd0, 64'd1);
      send_cmd(FUNC_LOAD, 64'd7, 64'd0, 64'd0, 64'd1);
      send_cmd(FUNC_LOAD, 64'd5, 64'd0, 64'd0, 64'h8000_0000_0000_0000);
      send_cmd(FUNC_SELECT, .tgt(64'd26));
      send_cmd(FUNC_SELECT, .tgt(64'd13));
      send_cmd(FUNC_SELECT, .tgt(64'd1));
      drain();
      send_cmd(FUNC_CLEAR);
      send_cmd(FUNC_LOAD, '1, 64'd0, 64'd0, 64'd0);
      send_cmd(FUNC_SELECT, .tgt('1));
      send_cmd(FUNC_LOAD, 64'd1, 64'd0, 64'd0, 64'd0);
      send_cmd(FUNC_SELECT, .tgt(64'd1));
      drain();
   endtask

   task automatic test_filters();
      set_config(64'd100, 1'b1, 64'd9);
      send_cmd(FUNC_CLEAR);
      send_cmd(FUNC_LOAD, 64'd4, 64'd100, 64'd9, 64'd0);
      send_cmd(FUNC_LOAD, 64'd3, 64'd101, 64'd9, 64'd0);
      send_cmd(FUNC_LOAD, 64'd2, 64'd0, 64'd0, 64'd0);
      send_cmd(FUNC_LOAD, 64'd1, '1, '1, '1);
      send_cmd(FUNC_SELECT, .tgt(64'd4));
      send_cmd(FUNC_SELECT, .tgt(64'd5));
      drain();
      set_config('1, 1'b1, '1);
      send_cmd(FUNC_SELECT, .tgt(64'd1));
      drain();
      set_config('1, 1'b0, 64'd0);
      send_cmd(FUNC_SELECT, .tgt(64'd10));
      drain();
   endtask

   task automatic test_full_store();
      logic [63:0] sum;
      sum = 0;
      set_config('1, 1'b0, 64'd0);
      send_cmd(FUNC_CLEAR);
      for (int i = 0; i < STORE_DEPTH + 2; i++) begin
         logic [63:0] a;
         a = 64'($urandom_range(1, 5000));
         if (i < STORE_DEPTH) sum += a;
         send_cmd(FUNC_LOAD, a, rnd64(), rnd64(), 64'($urandom_range(3)));
      end
      send_cmd(FUNC_SELECT, .tgt(sum));
      send_cmd(FUNC_SELECT, .tgt(sum + 64'd1));
      drain();
   endtask

   task automatic test_pressure();
      set_config(64'd1000, 1'b0, 64'd0);
      send_cmd(FUNC_CLEAR);
      for (int i = 1; i <= 6; i++) send_cmd(FUNC_LOAD, 64'(i), 64'd0, 64'd0, 64'(7 - i));
      hold_ask = 600;
      repeat (4) send_cmd(FUNC_SELECT, .tgt(64'd21));
      send_cmd(FUNC_LOAD, 64'd2, 64'd0, 64'd0, 64'd0);
      send_cmd(FUNC_SELECT, .tgt(64'd3));
      drain();
   endtask

   task automatic test_random(int n_items);
      int          sent;
      int          roll;
      logic [63:0] amt, unl, tok, tgt;
      sent = 0;
      while (sent < n_items) begin
         if (sent % 50 == 0) begin
            drain();
            case ($urandom_range(3))
               0: set_config('1, 1'b0, 64'd0);
               1: set_config(64'd0, 1'b1, '1);
               2: set_config(rnd64(), 1'b1, 64'd0);
               default: set_config(64'd500, 1'($urandom_range(1)), 64'd5);
            endcase
            no_idle = (sent == 50) || ($urandom_range(3) == 0);
         end
         roll = $urandom_range(99);
         if (roll < 8) begin
            send_cmd(FUNC_CLEAR);
         end else if (roll < 63) begin
            if (coin_total_n >= 12) send_cmd(FUNC_CLEAR);
            case ($urandom_range(9))
               0: amt = rnd64();
               1: amt = '1;
               2: amt = 0;
               default: amt = 64'($urandom_range(1, 8) * $urandom_range(1, 200));
            endcase
            case ($urandom_range(3))
               0: unl = rnd64();
               1: unl = 0;
               default: unl = 64'($urandom_range(0, 1000));
            endcase
            case ($urandom_range(4))
               0: tok = rnd64();
               1: tok = cfg_tag;
               2: tok = 64'd5;
               default: tok = 0;
            endcase
            send_cmd(FUNC_LOAD, amt, unl, tok,
                     $urandom_range(1) ? 64'($urandom_range(3)) : rnd64());
         end else if (roll < 96) begin
            case ($urandom_range(9))
               0: tgt = 0;
               1: tgt = rnd64();
               2: tgt = '1;
               default: tgt = 64'($urandom_range(1, 3000));
            endcase
            send_cmd(FUNC_SELECT, rnd64(), rnd64(), rnd64(), rnd64(), tgt);
         end else begin
            send_cmd(FUNC_SPARE, rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
            sent--;
         end
         sent++;
      end
      no_idle = 0;
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_errors();
      test_ordering();
      test_filters();
      test_full_store();
      test_pressure();
      test_random(100);
      $display("Covered %0d selections (%0d successful), %0d result transfers, %0d errors.",
               selects_sent, ok_selects, results_seen, err_results);
      if (mismatches == 0 && expected_picks.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_picks.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("Timeout with %0d results outstanding", expected_picks.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ smallest_first_coin_selector.f @@
src/csfs_pkg.sv
src/csfs_front.sv
src/csfs_back.sv
src/smallest_first_coin_selector.sv
dv/tb_smallest_first_coin_selector.sv
